/* rtl/nht_pkg.sv */
`default_nettype none
package nht_pkg;

    // input item, as it arrives on the s_ channel
    typedef struct packed {
        logic       cmd;
        logic [9:0] frame_length;
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] node_id;
        logic       link_ready;
    } in_item_t;

    // result item, as it leaves on the m_ channel
    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] event_node;
        logic       last_event;
    } out_item_t;

    // command codes
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // frame checks
    localparam logic [9:0] FRAME_LEN  = 10'd21;
    localparam logic [7:0] HDR_FIRST  = 8'hFF;
    localparam logic [7:0] HDR_SECOND = 8'hFE;

    // event kinds
    localparam logic [2:0] KIND_ONLINE  = 3'd0;
    localparam logic [2:0] KIND_REFRESH = 3'd1;
    localparam logic [2:0] KIND_UNKNOWN = 3'd2;
    localparam logic [2:0] KIND_HEADER  = 3'd3;
    localparam logic [2:0] KIND_OFFLINE = 3'd4;

    // offline reports per scan are capped
    localparam int         MAX_RESULTS = 16;
    localparam logic [4:0] MAX_REPORTS = 5'd16;

    // register map, indexed by the word address
    localparam logic REG_SCAN_PERIOD     = 1'b0;
    localparam logic REG_OFFLINE_TIMEOUT = 1'b1;

    localparam logic [15:0] SCAN_PERIOD_RESET     = 16'd1000;
    localparam logic [19:0] OFFLINE_TIMEOUT_RESET = 20'd15000;

    // classified work handed from front to back
    typedef enum logic [1:0] {
        Q_HEADER,
        Q_UNKNOWN,
        Q_STAMP,
        Q_TICK
    } q_kind_t;

    typedef struct packed {
        q_kind_t    kind;
        logic [7:0] node;
        logic       ready;
    } q_entry_t;

endpackage
`default_nettype wire

/* rtl/nht_ram.sv */
`default_nettype none
module nht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/nht_front.sv */
`default_nettype none
module nht_front
    import nht_pkg::*;
#(
    parameter int NODES = 16
) (
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          push,
    output q_entry_t      push_entry,
    input  wire logic     q_full
);

    localparam logic [7:0] NODES_ID = 8'(NODES);

    logic keep;

    // classify the item; frames of the wrong length are taken and dropped
    always_comb begin
        keep             = 1'b1;
        push_entry.kind  = Q_TICK;
        push_entry.node  = s_data.node_id;
        push_entry.ready = s_data.link_ready;
        if (s_data.cmd == CMD_TICK) begin
            push_entry.kind = Q_TICK;
        end else if (s_data.frame_length != FRAME_LEN) begin
            keep = 1'b0;
        end else if (s_data.header_first != HDR_FIRST ||
                     s_data.header_second != HDR_SECOND) begin
            push_entry.kind = Q_HEADER;
        end else if (s_data.node_id == 8'd0 || s_data.node_id > NODES_ID) begin
            push_entry.kind = Q_UNKNOWN;
        end else begin
            push_entry.kind = Q_STAMP;
        end
    end

    assign s_ready = ~q_full;
    assign push    = s_valid & s_ready & keep;

endmodule
`default_nettype wire

/* rtl/nht_queue.sv */
`default_nettype none
module nht_queue
    import nht_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    output logic          full,
    output logic          q_valid,
    output q_entry_t      q_entry,
    input  wire logic     pop
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = slot_reg[rd_ptr_reg];

    // two-entry queue between front and back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= push_entry;
                wr_ptr_reg           <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/nht_back.sv */
`default_nettype none
module nht_back
    import nht_pkg::*;
#(
    parameter int NODES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire q_entry_t    q_entry,
    output logic             pop,
    input  wire logic [15:0] scan_period,
    input  wire logic [19:0] offline_timeout,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W = $clog2(NODES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_CHK,
        ST_SCAN_CMP,
        ST_SCAN_END
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [31:0]      now_reg, now_next;
    logic [31:0]      last_scan_reg, last_scan_next;
    logic [NODES-1:0] online_reg, online_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [7:0]       hold_node_reg, hold_node_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             ram_we;
    logic [IDX_W-1:0] stamp_slot;
    logic [IDX_W-1:0] scan_slot;
    logic [31:0]      ram_rdata;
    logic [31:0]      now_inc;
    logic [7:0]       stamp_id;
    logic [7:0]       scan_node;
    logic             out_free;
    logic             hit;

    assign out_free   = ~m_valid_reg | m_ready;
    assign now_inc    = now_reg + 32'd1;
    assign stamp_id   = q_entry.node - 8'd1;
    assign stamp_slot = stamp_id[IDX_W-1:0];
    assign scan_slot  = idx_reg[IDX_W-1:0];
    assign scan_node  = 8'(idx_reg) + 8'd1;
    assign hit        = (now_reg - ram_rdata) > {12'd0, offline_timeout};

    // last-seen stamps
    nht_ram #(
        .WIDTH(32),
        .DEPTH(NODES)
    ) u_seen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (stamp_slot),
        .wdata (now_reg),
        .raddr (scan_slot),
        .rdata (ram_rdata)
    );

    // sequencer: frame results, ticks and the per-node scan
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        last_scan_next  = last_scan_reg;
        online_next     = online_reg;
        hold_valid_next = hold_valid_reg;
        hold_node_next  = hold_node_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_data_next     = m_data_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_entry.kind)
                        Q_HEADER: begin
                            if (out_free) begin
                                pop                     = 1'b1;
                                m_valid_next            = 1'b1;
                                m_data_next.event_kind  = KIND_HEADER;
                                m_data_next.event_node  = 8'd0;
                                m_data_next.last_event  = 1'b1;
                            end
                        end
                        Q_UNKNOWN: begin
                            if (out_free) begin
                                pop                     = 1'b1;
                                m_valid_next            = 1'b1;
                                m_data_next.event_kind  = KIND_UNKNOWN;
                                m_data_next.event_node  = q_entry.node;
                                m_data_next.last_event  = 1'b1;
                            end
                        end
                        Q_STAMP: begin
                            if (out_free) begin
                                pop                     = 1'b1;
                                ram_we                  = 1'b1;
                                online_next[stamp_slot] = 1'b1;
                                m_valid_next            = 1'b1;
                                m_data_next.event_kind  = online_reg[stamp_slot] ?
                                                          KIND_REFRESH : KIND_ONLINE;
                                m_data_next.event_node  = q_entry.node;
                                m_data_next.last_event  = 1'b1;
                            end
                        end
                        Q_TICK: begin
                            pop      = 1'b1;
                            now_next = now_inc;
                            if (q_entry.ready &&
                                (now_inc - last_scan_reg) >= {16'd0, scan_period}) begin
                                last_scan_next = now_inc;
                                idx_next       = '0;
                                cnt_next       = 5'd0;
                                state_next     = ST_SCAN_CHK;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN_CHK: begin
                if (idx_reg == CNT_W'(NODES) || cnt_reg == MAX_REPORTS) begin
                    state_next = ST_SCAN_END;
                end else if (online_reg[scan_slot]) begin
                    state_next = ST_SCAN_CMP;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_SCAN_CMP: begin
                if (!hit) begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_SCAN_CHK;
                end else if (!hold_valid_reg || out_free) begin
                    // the held report is not the last one: send it on
                    if (hold_valid_reg) begin
                        m_valid_next           = 1'b1;
                        m_data_next.event_kind = KIND_OFFLINE;
                        m_data_next.event_node = hold_node_reg;
                        m_data_next.last_event = 1'b0;
                    end
                    hold_valid_next        = 1'b1;
                    hold_node_next         = scan_node;
                    online_next[scan_slot] = 1'b0;
                    cnt_next               = cnt_reg + 5'd1;
                    idx_next               = idx_reg + CNT_W'(1);
                    state_next             = ST_SCAN_CHK;
                end
            end
            ST_SCAN_END: begin
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.event_kind = KIND_OFFLINE;
                    m_data_next.event_node = hold_node_reg;
                    m_data_next.last_event = 1'b1;
                    hold_valid_next        = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= 32'd0;
            last_scan_reg  <= 32'd0;
            online_reg     <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            last_scan_reg  <= last_scan_next;
            online_reg     <= online_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        hold_node_reg <= hold_node_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // a held offline report exists only while a scan runs
    a_hold_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> state_reg != ST_IDLE)
        else $error("held report outside a scan");

    // never more offline reports than the cap in one scan
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> cnt_reg <= MAX_REPORTS)
        else $error("offline report count over cap");

    // the compared node is still online
    a_cmp_online: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN_CMP |-> online_reg[scan_slot])
        else $error("comparing an offline node");

    // a tick advances the clock by exactly one
    a_tick_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_entry.kind == Q_TICK) |=> now_reg == $past(now_reg) + 32'd1)
        else $error("tick did not advance the clock");
`endif

endmodule
`default_nettype wire

/* rtl/node_heartbeat_tracker.sv */
`default_nettype none
// node liveness tracker
// s_ channel: one item per frame summary (cmd 0) or per millisecond tick (cmd 1).
// m_ channel: event items (online, refresh, unknown id, header error, offline);
//   last_event marks the final item caused by one input item.
// frames of the wrong length are taken and give no item.
// the front classifies an item in the cycle it is taken and writes a two-entry
//   queue; the back sequencer reads the queue and fills the output register.
// a taken frame passes the queue, then the output register, before m_valid rises;
//   one item per cycle while no scan runs and m_ready is high.
// a due scan (on a tick) visits the check state for every node, the compare
//   state for an online node (registered last-seen read), then the end state.
// the front keeps taking items while the back scans, until the queue is full.
// when m_ready is low the output register and emitting steps hold; nothing lost.
// reset (aresetn low at a clock edge) clears the clock, the online flags and
//   loads the register defaults; last-seen stamps are written before first use.
// registers: 0x0 scan period in ms, 0x4 offline timeout in ms.
module node_heartbeat_tracker
    import nht_pkg::*;
#(
    parameter int NODES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] scan_period_reg;
    logic [19:0] offline_timeout_reg;
    logic        push;
    q_entry_t    push_entry;
    logic        q_full;
    logic        q_valid;
    q_entry_t    q_entry;
    logic        pop;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_period_reg     <= SCAN_PERIOD_RESET;
            offline_timeout_reg <= OFFLINE_TIMEOUT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_SCAN_PERIOD:     scan_period_reg     <= pwdata[15:0];
                REG_OFFLINE_TIMEOUT: offline_timeout_reg <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            REG_SCAN_PERIOD:     prdata = {16'd0, scan_period_reg};
            REG_OFFLINE_TIMEOUT: prdata = {12'd0, offline_timeout_reg};
            default:             prdata = 32'd0;
        endcase
    end

    nht_front #(
        .NODES(NODES)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    nht_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    nht_back #(
        .NODES(NODES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_entry         (q_entry),
        .pop             (pop),
        .scan_period     (scan_period_reg),
        .offline_timeout (offline_timeout_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule
`default_nettype wire
